// ===== rtl/cursor_linked_list_free_pool_top_assert.svh =====
// Assertion macros shared by the free pool RTL modules.
`ifndef CURSOR_LINKED_LIST_FREE_POOL_TOP_ASSERT_SVH
`define CURSOR_LINKED_LIST_FREE_POOL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define CLLFP_CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CLLFP_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Plain invariant.
`define CLLFP_CHK_ALW(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cons)) else $error(msg);

`endif

// ===== rtl/cllfp_pkg.sv =====
// Types and codes for the cursor linked list free pool.
package cllfp_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DELETED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
  } out_t;

  typedef struct packed {
    logic load;
    logic ins_read;
    logic ins_commit;
    logic walk_read;
    logic walk_step;
    logic unlink;
    logic free_push;
    logic res_full;
    logic res_nf;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic free_null;
    logic cur_null;
    logic match;
    logic nxt_null;
    logic steps_last;
  } sts_t;

endpackage

// ===== rtl/cllfp_dp.sv =====
// Datapath: element and link stores, list heads, walk registers, result.
`include "cursor_linked_list_free_pool_top_assert.svh"
module cllfp_dp #(
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cllfp_pkg::in_t  in_data,
  input  cllfp_pkg::cmd_t cmd,
  output cllfp_pkg::sts_t sts,
  output cllfp_pkg::out_t out_data
);
  import cllfp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  logic [31:0]   elem_mem [DEPTH];
  logic [LW-1:0] link_mem [DEPTH];

  logic [31:0]   val_r;
  logic [LW-1:0] list_head_r, list_head_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] fresh_r, fresh_nxt;
  logic [LW-1:0] cur_r, prev_r;
  logic [AW-1:0] steps_r;
  logic [31:0]   elem_q_r;
  logic [LW-1:0] link_q_r;
  logic [AW-1:0] lrd_addr_r;
  out_t          res_r;
  out_t          out_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          lw_en;
  logic [AW-1:0] lw_addr;
  logic [LW-1:0] lw_data;
  logic [LW-1:0] link_rd;

  // slots below the fill mark still hold their reset link
  always_comb begin
    if (LW'(lrd_addr_r) < fresh_r) begin
      link_rd = (lrd_addr_r == '0) ? NIL : LW'(lrd_addr_r) - LW'(1);
    end else begin
      link_rd = link_q_r;
    end
  end

  always_comb begin
    rd_en   = cmd.ins_read | cmd.walk_read | cmd.walk_step;
    rd_addr = '0;
    if (cmd.ins_read) begin
      rd_addr = free_head_r[AW-1:0];
    end else if (cmd.walk_read) begin
      rd_addr = cur_r[AW-1:0];
    end else if (cmd.walk_step) begin
      rd_addr = link_rd[AW-1:0];
    end
  end

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    if (cmd.ins_commit) begin
      lw_en   = 1'b1;
      lw_addr = free_head_r[AW-1:0];
      lw_data = list_head_r;
      list_head_nxt = free_head_r;
      free_head_nxt = link_rd;
    end else if (cmd.unlink) begin
      if (prev_r < NIL) begin
        lw_en   = 1'b1;
        lw_addr = prev_r[AW-1:0];
        lw_data = link_rd;
      end else begin
        list_head_nxt = link_rd;
      end
    end else if (cmd.free_push) begin
      lw_en   = 1'b1;
      lw_addr = cur_r[AW-1:0];
      lw_data = free_head_r;
      free_head_nxt = cur_r;
    end
  end

  always_comb begin
    fresh_nxt = fresh_r;
    if (lw_en && fresh_r != '0 && LW'(lw_addr) == fresh_r - LW'(1)) begin
      fresh_nxt = fresh_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_head_r <= NIL;
      free_head_r <= LW'(DEPTH - 1);
      fresh_r     <= LW'(DEPTH);
    end else begin
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_commit) begin
      elem_mem[free_head_r[AW-1:0]] <= val_r;
    end
    if (rd_en) begin
      elem_q_r <= elem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (rd_en) begin
      link_q_r   <= link_mem[rd_addr];
      lrd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r   <= in_data.value;
      cur_r   <= list_head_r;
      prev_r  <= NIL;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      prev_r  <= cur_r;
      cur_r   <= link_rd;
      steps_r <= steps_r + AW'(1);
    end
    if (cmd.ins_commit) begin
      res_r <= '{status: ST_INSERTED, slot: 3'(free_head_r)};
    end else if (cmd.free_push) begin
      res_r <= '{status: ST_DELETED, slot: 3'(cur_r)};
    end else if (cmd.res_full) begin
      res_r <= '{status: ST_FULL, slot: 3'd0};
    end else if (cmd.res_nf) begin
      res_r <= '{status: ST_NOT_FOUND, slot: 3'd0};
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign sts.free_null  = (free_head_r >= NIL);
  assign sts.cur_null   = (cur_r >= NIL);
  assign sts.match      = (elem_q_r == val_r);
  assign sts.nxt_null   = (link_rd >= NIL);
  assign sts.steps_last = (steps_r == AW'(DEPTH - 1));
  assign out_data       = out_r;

  `CLLFP_CHK_ALW(a_heads_differ, !(free_head_r < NIL && list_head_r < NIL) || (free_head_r != list_head_r), "free and list heads share a slot")
  `CLLFP_CHK_NXT(a_fill_mark_falls, 1'b1, fresh_r <= $past(fresh_r), "fill mark rose")
  `CLLFP_CHK_NXT(a_insert_at_front, cmd.ins_commit, list_head_r == $past(free_head_r), "inserted slot not at list front")

endmodule

// ===== rtl/cllfp_ctrl.sv =====
// Controller: sequences insert, delete walk and result handoff.
`include "cursor_linked_list_free_pool_top_assert.svh"
module cllfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cllfp_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  input  cllfp_pkg::sts_t sts,
  output cllfp_pkg::cmd_t cmd
);
  import cllfp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FREE   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_data.opcode == OP_INSERT) begin
            if (sts.free_null) begin
              cmd.res_full = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.ins_read = 1'b1;
              state_nxt    = S_INS;
            end
          end else begin
            state_nxt = S_DSTART;
          end
        end
      end
      S_INS: begin
        cmd.ins_commit = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DSTART: begin
        if (sts.cur_null) begin
          cmd.res_nf = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.walk_read = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.match) begin
          cmd.unlink = 1'b1;
          state_nxt  = S_FREE;
        end else if (sts.nxt_null || sts.steps_last) begin
          cmd.res_nf = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.free_push = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CLLFP_CHK_ALW(a_one_result, $onehot0({cmd.res_full, cmd.res_nf, cmd.ins_commit, cmd.free_push}), "two results in one cycle")
  `CLLFP_CHK_NXT(a_accept_busy, accept, state_r != S_IDLE, "accepted beat left controller idle")
  `CLLFP_CHK_NXT(a_done_holds, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE, "result dropped while output full")

endmodule

// ===== rtl/cursor_linked_list_free_pool_top.sv =====
// Top level of the cursor linked list free pool.
// A pool of DEPTH slots holds one singly linked list and a free list that
// share one link store. Input beats (in_valid/in_stall/in_data) carry an
// opcode and a 32-bit value: insert puts the value in the free-list head
// slot at the list front, delete removes the first slot holding the value.
// Each input beat gives one output beat (out_valid/out_stall/out_data)
// with a status and the slot used.
// One item at a time. A delete visits at most DEPTH slots, with one
// link-store read each. The next beat is taken the cycle after the
// result moves into the output register.
// Reset (rst_n low, synchronous) empties the list and puts every slot on
// the free list, top slot first; reset links are served by a fill mark,
// so no clearing pass is needed. While out_stall holds a result, the
// output beat stays put; the block still takes and works one more beat,
// then holds that result and stalls its input until the output frees.
module cursor_linked_list_free_pool_top #(
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cllfp_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cllfp_pkg::out_t out_data
);
  import cllfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cllfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cllfp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== bench/cursor_linked_list_free_pool_top_tb.sv =====
// Self-checking testbench for the cursor linked list free pool: directed table, then random traffic.
module cursor_linked_list_free_pool_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cllfp_pkg::*;

  localparam int DEPTH          = 8;
  localparam int NIL            = DEPTH;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 560;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] value;
    logic        fixed;
    logic [1:0]  status;
    logic [2:0]  slot;
  } dir_row_t;

  localparam int DIR_ROWS_N = 23;
  // rows with fixed set carry a hand-written result; the rest use the predictor
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{OP_DELETE, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 3'd0},
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, ST_INSERTED,  3'd7},
    '{OP_INSERT, 32'h8000_0000, 1'b1, ST_INSERTED,  3'd6},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, ST_INSERTED,  3'd5},
    '{OP_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED,  3'd4},
    '{OP_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED,  3'd3},
    '{OP_INSERT, 32'h0000_0001, 1'b1, ST_INSERTED,  3'd2},
    '{OP_INSERT, 32'h5555_5555, 1'b1, ST_INSERTED,  3'd1},
    '{OP_INSERT, 32'haaaa_aaaa, 1'b1, ST_INSERTED,  3'd0},
    '{OP_INSERT, 32'h0000_0005, 1'b1, ST_FULL,      3'd0},
    '{OP_DELETE, 32'h0000_007b, 1'b1, ST_NOT_FOUND, 3'd0},
    '{OP_DELETE, 32'h0000_0000, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h7fff_ffff, 1'b0, ST_INSERTED,  3'd0},
    '{OP_INSERT, 32'h0000_0009, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'haaaa_aaaa, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h0000_0000, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h0000_0000, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'hffff_ffff, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h8000_0000, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h0000_0001, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h5555_5555, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h0000_0009, 1'b0, ST_INSERTED,  3'd0},
    '{OP_DELETE, 32'h0000_0009, 1'b1, ST_NOT_FOUND, 3'd0}
  };

  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff,
    32'h8000_0000, 32'h0000_0003, 32'h0000_002a, 32'h0000_03e8
  };

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  cursor_linked_list_free_pool_top #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] pool_elem [DEPTH];
  int          pool_link [DEPTH];
  int          pool_list_head;
  int          pool_free_head;

  out_t        due_results [$];
  out_t        awaited;
  int          errors        = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          insert_bias   = 50;
  logic        hold_req      = 1'b0;
  int          hold_count    = 0;
  int          quiet_cycles  = 0;

  function automatic void reset_pool();
    for (int i = 0; i < DEPTH; i++) begin
      pool_elem[i] = '0;
      pool_link[i] = (i == 0) ? NIL : i - 1;
    end
    pool_list_head = NIL;
    pool_free_head = DEPTH - 1;
  endfunction

  function automatic out_t apply_pool_op(input in_t item);
    out_t res;
    int   prev;
    int   cur;
    int   steps;
    res.status = ST_NOT_FOUND;
    res.slot   = '0;
    prev       = NIL;
    cur        = pool_list_head;
    steps      = 0;
    if (item.opcode == OP_INSERT) begin
      if (pool_free_head >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        cur            = pool_free_head;
        pool_free_head = pool_link[cur];
        pool_elem[cur] = item.value;
        pool_link[cur] = pool_list_head;
        pool_list_head = cur;
        res.status     = ST_INSERTED;
        res.slot       = 3'(cur);
      end
    end else begin
      while (cur < DEPTH && steps < DEPTH && pool_elem[cur] != item.value) begin
        prev  = cur;
        cur   = pool_link[cur];
        steps = steps + 1;
      end
      if (cur < DEPTH && pool_elem[cur] == item.value) begin
        if (prev < DEPTH) begin
          pool_link[prev] = pool_link[cur];
        end else begin
          pool_list_head = pool_link[cur];
        end
        pool_link[cur] = pool_free_head;
        pool_free_head = cur;
        res.status     = ST_DELETED;
        res.slot       = 3'(cur);
      end
    end
    return res;
  endfunction

  function automatic in_t random_pool_op();
    in_t item;
    item.opcode = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_DELETE;
    if ($urandom_range(99) < 15) begin
      item.value = $urandom;
    end else begin
      item.value = VALUE_POOL[$urandom_range(7)];
    end
    return item;
  endfunction

  task automatic send_item(input in_t item, input logic fixed, input out_t fixed_res);
    out_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_pool_op(item);
    due_results.push_back(fixed ? fixed_res : predicted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat status %0d slot %0d",
                 $time, out_data.status, out_data.slot);
        errors++;
      end else begin
        awaited = due_results.pop_front();
        if (out_data.status !== awaited.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, awaited.status, out_data.status);
          errors++;
        end
        if (out_data.slot !== awaited.slot) begin
          $display("%0t: slot mismatch, expected %0d, actual %0d",
                   $time, awaited.slot, out_data.slot);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_t  item;
    out_t fixed_res;
    reset_pool();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS_N; r++) begin
      item.opcode      = DIR_ROWS[r].opcode;
      item.value       = DIR_ROWS[r].value;
      fixed_res.status = DIR_ROWS[r].status;
      fixed_res.slot   = DIR_ROWS[r].slot;
      send_item(item, DIR_ROWS[r].fixed, fixed_res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // vary the insert/delete mix so the pool swings between empty and full
        if (n % 40 == 0) insert_bias = 20 + 30 * $urandom_range(2);
        if (phase == 2 && n == 100) hold_req <= 1'b1;
        send_item(random_pool_op(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
